// ===== design/tctt_pkg.sv =====
// shared types and constants for the tcp connection timer table
// no dependencies

package tctt_pkg;

	// input event codes
	typedef enum logic [2:0] {
		MODE_TICK         = 3'd0,
		MODE_ARM_TW       = 3'd1,
		MODE_ARM_RT       = 3'd2,
		MODE_DISARM_RT    = 3'd3,
		MODE_ACK          = 3'd4,
		MODE_ARM_PS       = 3'd5,
		MODE_DISARM_PS    = 3'd6,
		MODE_SET_FLAGS    = 3'd7
	} mode_t;

	// result action codes
	typedef enum logic [2:0] {
		ACT_TW_CLOSE   = 3'd0,
		ACT_RETRANSMIT = 3'd1,
		ACT_GIVE_UP    = 3'd2,
		ACT_RT_DROPPED = 3'd3,
		ACT_PROBE      = 3'd4,
		ACT_PS_STOPPED = 3'd5,
		ACT_WAKE       = 3'd6
	} act_t;

	// configuration register indexes
	localparam logic [1:0] CFG_SCAN_STEP  = 2'd0;
	localparam logic [1:0] CFG_RT_INITIAL = 2'd1;
	localparam logic [1:0] CFG_TW_TIMEOUT = 2'd2;
	localparam logic [1:0] CFG_RETRY_LIM  = 2'd3;

	localparam logic [23:0] RST_SCAN_STEP  = 24'd10000;
	localparam logic [23:0] RST_RT_INITIAL = 24'd200000;
	localparam logic [23:0] RST_TW_TIMEOUT = 24'd2000000;
	localparam logic [2:0]  RST_RETRY_LIM  = 3'd3;

	localparam logic [1:0] FLAG_CLOSED = 2'b01;

	// one connection entry as held in memory
	typedef struct packed {
		logic        tw_on;
		logic [31:0] tw_left;
		logic        rt_on;
		logic [31:0] rt_left;
		logic [2:0]  retry;
		logic        ps_on;
		logic [31:0] ps_left;
		logic [1:0]  flags;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// configuration values seen by the update logic
	typedef struct packed {
		logic [23:0] scan_step;
		logic [23:0] rt_initial;
		logic [23:0] tw_timeout;
		logic [2:0]  retry_lim;
	} cfg_t;

	// updated entry and up to three actions, slot 0 first
	typedef struct packed {
		entry_t     ent;
		logic [2:0] mask;
		act_t       code0;
		act_t       code1;
		act_t       code2;
	} upd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_EMIT,
		ST_FLUSH
	} state_t;

endpackage

// ===== design/tctt_mem.sv =====
// connection entry memory with registered read, with per-entry valid bits
// depends on tctt_pkg

module tctt_mem
	import tctt_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t           mem [DEPTH];
	entry_t           raw_q;
	logic             rd_vld_q;
	logic [DEPTH-1:0] vld_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	// valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? raw_q : '0;

endmodule

// ===== design/tctt_upd.sv =====
// per-entry update: tick countdown and expiry, or one event
// depends on tctt_pkg

module tctt_upd
	import tctt_pkg::*;
(
	input  entry_t ent,
	input  mode_t  mode,
	input  logic   send_empty,
	input  logic   closed_flag,
	input  logic   window_small,
	input  cfg_t   cfg,
	output upd_t   upd
);

	logic [31:0] step;
	logic [31:0] init;
	logic [2:0]  rc_next;

	assign step    = {8'd0, cfg.scan_step};
	assign init    = {8'd0, cfg.rt_initial};
	assign rc_next = ent.retry + 3'd1;

	always_comb begin
		upd       = '0;
		upd.ent   = ent;
		upd.code0 = ACT_TW_CLOSE;
		upd.code1 = ACT_TW_CLOSE;
		upd.code2 = ACT_TW_CLOSE;
		case (mode)
			MODE_TICK: begin
				// time-wait timer
				if (ent.tw_on) begin
					if (ent.tw_left <= step) begin
						upd.ent.tw_on = 1'b0;
						upd.ent.flags = upd.ent.flags | FLAG_CLOSED;
						upd.mask[0]   = 1'b1;
						upd.code0     = ACT_TW_CLOSE;
					end else begin
						upd.ent.tw_left = ent.tw_left - step;
					end
				end
				// retransmit timer, sees a close from time-wait above
				if (ent.rt_on) begin
					if (ent.rt_left <= step) begin
						upd.mask[1] = 1'b1;
						if (upd.ent.flags[0]) begin
							upd.ent.rt_on = 1'b0;
							upd.code1     = ACT_RT_DROPPED;
						end else if (ent.retry >= cfg.retry_lim) begin
							upd.ent.rt_on = 1'b0;
							upd.ent.flags = upd.ent.flags | FLAG_CLOSED;
							upd.code1     = ACT_GIVE_UP;
						end else begin
							upd.ent.retry   = rc_next;
							upd.ent.rt_left = init << rc_next;
							upd.code1       = ACT_RETRANSMIT;
						end
					end else begin
						upd.ent.rt_left = ent.rt_left - step;
					end
				end
				// persist timer
				if (ent.ps_on) begin
					if (ent.ps_left <= step) begin
						upd.mask[2] = 1'b1;
						if (!upd.ent.flags[0] && upd.ent.flags[1]) begin
							upd.ent.ps_left = init;
							upd.code2       = ACT_PROBE;
						end else begin
							upd.ent.ps_on = 1'b0;
							upd.code2     = ACT_PS_STOPPED;
						end
					end else begin
						upd.ent.ps_left = ent.ps_left - step;
					end
				end
			end
			MODE_ARM_TW: begin
				if (!ent.tw_on) begin
					upd.ent.tw_on   = 1'b1;
					upd.ent.tw_left = {8'd0, cfg.tw_timeout};
				end
			end
			MODE_ARM_RT: begin
				if (!ent.rt_on) begin
					upd.ent.rt_on = 1'b1;
					upd.ent.retry = 3'd0;
				end
				upd.ent.rt_left = init;
			end
			MODE_DISARM_RT: begin
				upd.ent.rt_on = 1'b0;
			end
			MODE_ACK: begin
				if (ent.rt_on) begin
					if (send_empty) begin
						upd.ent.rt_on = 1'b0;
						upd.mask[0]   = 1'b1;
						upd.code0     = ACT_WAKE;
					end else begin
						upd.ent.rt_left = init;
						upd.ent.retry   = 3'd0;
					end
				end
			end
			MODE_ARM_PS: begin
				if (!ent.ps_on) begin
					upd.ent.ps_on   = 1'b1;
					upd.ent.ps_left = init;
				end
			end
			MODE_DISARM_PS: begin
				upd.ent.ps_on = 1'b0;
			end
			MODE_SET_FLAGS: begin
				upd.ent.flags = {window_small, closed_flag};
			end
			default: begin
				upd.ent = ent;
			end
		endcase
	end

endmodule

// ===== design/tcp_connection_timer_table_top.sv =====
// top level of the tcp connection timer table: sequencer, output staging
// depends on tctt_pkg, tctt_mem, tctt_upd
//
//  channel | signals                                        | dir
//  in      | in_valid in_ready mode conn send_empty         | in
//          | closed_flag window_small                       |
//  out     | out_valid out_ready out_conn action last       | out
//  cfg     | cfg_we cfg_idx cfg_wdata                       | in
//
// an event goes through memory read, update and write back, then drain
// a tick visits every entry in order, with the read, update and write-back
// of one entry at a time, and then emits the actions of that entry
// reset clears the configuration to its defaults and all entries to zero
// through per-entry valid bits; no clearing pass is needed
// one action is held back so that last can be marked; a stalled output
// holds the sequencer in its emit or drain step

module tcp_connection_timer_table_top
	import tctt_pkg::*;
#(
	parameter int CONNS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [3:0]  conn,
	input  logic        send_empty,
	input  logic        closed_flag,
	input  logic        window_small,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  out_conn,
	output logic [2:0]  action,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_wdata
);

	localparam int IW = (CONNS > 1) ? $clog2(CONNS) : 1;

	state_t        state_q, state_d;
	cfg_t          cfg_q;
	mode_t         mode_q;
	logic          se_q, cl_q, sm_q;
	logic [IW-1:0] cnt_q;
	logic [2:0]    act_q;
	act_t          code0_q, code1_q, code2_q;
	logic          pend_v_q;
	logic [3:0]    pend_conn_q;
	act_t          pend_act_q;
	logic          out_valid_q;
	logic [3:0]    out_conn_q;
	act_t          out_act_q;
	logic          out_last_q;

	entry_t        rd_data;
	upd_t          upd;
	logic          rd_en, wr_en;
	logic          accept, in_range, out_free;
	logic          emit_take, flush_take, cnt_end;
	act_t          sel_act;
	logic [2:0]    sel_clr;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_range  = (32'(conn) < CONNS);
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_end   = (cnt_q == IW'(CONNS - 1));
	assign out_valid = out_valid_q;
	assign out_conn  = out_conn_q;
	assign action    = out_act_q;
	assign last      = out_last_q;

	tctt_mem #(
		.DEPTH (CONNS),
		.IW    (IW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (cnt_q),
		.wr_data (upd.ent)
	);

	tctt_upd u_upd (
		.ent          (rd_data),
		.mode         (mode_q),
		.send_empty   (se_q),
		.closed_flag  (cl_q),
		.window_small (sm_q),
		.cfg          (cfg_q),
		.upd          (upd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && ((mode_t'(mode) == MODE_TICK) || in_range)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: state_d = ST_EMIT;
			ST_EMIT: begin
				if (act_q == 3'b000) begin
					state_d = (mode_q == MODE_TICK && !cnt_end) ? ST_READ : ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// lowest pending action of the entry
	always_comb begin
		sel_act = code0_q;
		sel_clr = 3'b001;
		if (act_q[0]) begin
			sel_act = code0_q;
			sel_clr = 3'b001;
		end else if (act_q[1]) begin
			sel_act = code1_q;
			sel_clr = 3'b010;
		end else begin
			sel_act = code2_q;
			sel_clr = 3'b100;
		end
	end

	// control outputs
	always_comb begin
		rd_en      = (state_q == ST_READ);
		wr_en      = (state_q == ST_EVAL);
		emit_take  = (state_q == ST_EMIT) && (act_q != 3'b000) && (!pend_v_q || out_free);
		flush_take = (state_q == ST_FLUSH) && pend_v_q && out_free;
	end

	// sequencer and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			act_q   <= '0;
			mode_q  <= MODE_TICK;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q <= mode_t'(mode);
				cnt_q  <= (mode_t'(mode) == MODE_TICK) ? '0 : IW'(conn);
			end
			if (state_q == ST_EMIT && act_q == 3'b000 && state_d == ST_READ) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (state_q == ST_EVAL) begin
				act_q <= upd.mask;
			end else if (emit_take) begin
				act_q <= act_q & ~sel_clr;
			end
		end
	end

	// item payload and action codes
	always_ff @(posedge clk) begin
		if (accept) begin
			se_q <= send_empty;
			cl_q <= closed_flag;
			sm_q <= window_small;
		end
		if (state_q == ST_EVAL) begin
			code0_q <= upd.code0;
			code1_q <= upd.code1;
			code2_q <= upd.code2;
		end
	end

	// held-back word and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_take) begin
				pend_v_q <= 1'b1;
			end else if (flush_take) begin
				pend_v_q <= 1'b0;
			end
			if (flush_take || (emit_take && pend_v_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take) begin
			pend_conn_q <= 4'(cnt_q);
			pend_act_q  <= sel_act;
		end
		if (flush_take || (emit_take && pend_v_q)) begin
			out_conn_q <= pend_conn_q;
			out_act_q  <= pend_act_q;
			out_last_q <= flush_take;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_step  <= RST_SCAN_STEP;
			cfg_q.rt_initial <= RST_RT_INITIAL;
			cfg_q.tw_timeout <= RST_TW_TIMEOUT;
			cfg_q.retry_lim  <= RST_RETRY_LIM;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SCAN_STEP:  cfg_q.scan_step  <= cfg_wdata;
				CFG_RT_INITIAL: cfg_q.rt_initial <= cfg_wdata;
				CFG_TW_TIMEOUT: cfg_q.tw_timeout <= cfg_wdata;
				CFG_RETRY_LIM:  cfg_q.retry_lim  <= cfg_wdata[2:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// checks
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("held-back word left while idle");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !pend_v_q) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (32'(cnt_q) < CONNS))
		else $error("entry index out of range");

endmodule
